// ----- src/pbplru_pkg.sv -----
`default_nettype none
package pbplru_pkg;
    localparam int SLOTS = 16;
    localparam int SLOT_W = 4;
    localparam int CNT_W = 5;

    typedef enum logic [2:0] {
        CMD_ACCESS = 3'd0,
        CMD_DIRTY  = 3'd1,
        CMD_FLUSH  = 3'd2,
        CMD_PIN    = 3'd3,
        CMD_UNPIN  = 3'd4,
        CMD_SPILL  = 3'd5
    } cmd_t;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_NOT_RES = 2'd1;
    localparam logic [1:0] ST_NO_VICTIM = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_RDVIC,
        S_WRITE,
        S_OUT
    } state_t;

    // One memory word: tag and stamp of a slot.
    typedef struct packed {
        logic [7:0]  file;
        logic [15:0] page;
        logic [31:0] stamp;
    } entry_t;
endpackage
`default_nettype wire

// ----- src/page_buffer_pool_lru_manager.sv -----
`default_nettype none
// Channel   | Direction | Payload
// s_axis    | in        | tdata: command[2:0], page_file[10:3], page_number[26:11]
// m_axis    | out       | tdata: status, slot, hit, fetch_needed, writeback_valid,
//           |           |        writeback_file, writeback_page (lowest first)
// cfg       | in        | cfg_wdata: slots_in_use[4:0]
//
// One request is handled at a time. Tags and stamps live in a 16-entry memory
// with a registered read; a request scans all slots through that port, one per
// cycle. A hit or a refused request goes from the scan to the output, a fill of
// an empty slot also writes the entry, and an eviction first reads the victim's
// tag. The next request can be accepted in the cycle after the result is taken.
// Valid, pin, dirty and spilled marks are flip-flops cleared by reset.
// A finished result sits in the output register; the input is accepted again
// once that result has been taken.
module page_buffer_pool_lru_manager
    import pbplru_pkg::*;
(
    input  wire  logic        aclk,
    input  wire  logic        aresetn,
    input  wire  logic        s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire  logic [31:0] s_axis_tdata,   // command, page_file, page_number
    output logic              m_axis_tvalid,
    input  wire  logic        m_axis_tready,
    output logic [39:0]       m_axis_tdata,   // status, slot, hit, fetch, wb v/file/page
    input  wire  logic        cfg_wen,
    input  wire  logic [4:0]  cfg_wdata
);
    state_t state_reg, state_next;

    logic [4:0]        limit_reg;
    logic [SLOTS-1:0]  valid_reg, pin_reg, dirty_reg, spill_reg;
    logic [CNT_W-1:0]  occ_reg;
    logic [31:0]       opc_reg;

    logic [2:0]        cmd_reg;
    logic [7:0]        file_reg;
    logic [15:0]       page_reg;
    logic [CNT_W-1:0]  scan_reg;      // read address issued, runs to SLOTS
    logic              found_reg;
    logic [SLOT_W-1:0] found_idx_reg;
    logic [2:0]        best_ok_reg;
    logic [SLOT_W-1:0] best_idx_reg [3];
    logic [31:0]       best_st_reg  [3];
    logic [SLOT_W-1:0] tgt_reg;
    logic [39:0]       out_reg;
    logic              out_valid_reg;
    logic              hit_stamp_reg;

    logic              mem_we;
    logic [SLOT_W-1:0] mem_raddr;
    entry_t            mem_wdata, mem_rdata;

    logic [SLOT_W-1:0] rd_idx;
    logic              rd_live;
    logic [1:0]        cls;
    logic [CNT_W-1:0]  eff_limit;
    logic              vic_ok;
    logic [SLOT_W-1:0] vic_idx;

    assign rd_idx  = SLOT_W'(scan_reg - CNT_W'(1));
    assign rd_live = (state_reg == S_SCAN) && (scan_reg != '0);
    assign cls = spill_reg[rd_idx] ? 2'd2 : (dirty_reg[rd_idx] ? 2'd0 : 2'd1);
    assign eff_limit = (limit_reg == '0) ? CNT_W'(1)
                     : ((limit_reg > CNT_W'(SLOTS)) ? CNT_W'(SLOTS) : limit_reg);
    // The victim's tag is read while the decision is made, so it is ready
    // in S_RDVIC for the write-back report.
    assign mem_raddr = (state_reg == S_DECIDE) ? vic_idx : SLOT_W'(scan_reg);
    assign mem_we    = (state_reg == S_WRITE) || hit_stamp_reg;
    assign mem_wdata = '{file: file_reg, page: page_reg,
                         stamp: hit_stamp_reg ? (opc_reg - 32'd1) : opc_reg};

    pbplru_mem u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (tgt_reg),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign s_axis_tready = (state_reg == S_IDLE) && !out_valid_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;

    // Victim choice from the scan results.
    always_comb begin
        vic_ok  = 1'b1;
        vic_idx = best_idx_reg[0];
        if (best_ok_reg[0]) begin
            vic_idx = best_idx_reg[0];
        end else if (best_ok_reg[1]) begin
            vic_idx = best_idx_reg[1];
        end else if (best_ok_reg[2]) begin
            vic_idx = best_idx_reg[2];
        end else begin
            vic_ok = 1'b0;
        end
    end

    logic place_cmd, use_empty;
    assign place_cmd = (cmd_reg == CMD_ACCESS) || (cmd_reg == CMD_SPILL);
    assign use_empty = occ_reg < eff_limit;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (s_axis_tvalid && s_axis_tready) state_next = S_SCAN;
            S_SCAN:   if (scan_reg == CNT_W'(SLOTS)) state_next = S_DECIDE;
            S_DECIDE: begin
                if (cmd_reg > CMD_SPILL || found_reg || !place_cmd) begin
                    state_next = S_OUT;
                end else if (use_empty) begin
                    state_next = S_WRITE;
                end else if (vic_ok) begin
                    state_next = S_RDVIC;
                end else begin
                    state_next = S_OUT;
                end
            end
            S_RDVIC:  state_next = S_WRITE;
            S_WRITE:  state_next = S_OUT;
            S_OUT:    state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            limit_reg     <= 5'd16;
            valid_reg     <= '0;
            pin_reg       <= '0;
            dirty_reg     <= '0;
            spill_reg     <= '0;
            occ_reg       <= '0;
            opc_reg       <= '0;
            out_valid_reg <= 1'b0;
            scan_reg      <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_wen) limit_reg <= cfg_wdata;
            if (out_valid_reg && m_axis_tready) out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        cmd_reg     <= s_axis_tdata[2:0];
                        file_reg    <= s_axis_tdata[10:3];
                        page_reg    <= s_axis_tdata[26:11];
                        scan_reg    <= CNT_W'(1);
                        found_reg   <= 1'b0;
                        best_ok_reg <= '0;
                    end
                end
                S_SCAN: begin
                    if (scan_reg != CNT_W'(SLOTS)) scan_reg <= scan_reg + CNT_W'(1);
                    if (rd_live && valid_reg[rd_idx]) begin
                        if (!found_reg && mem_rdata.file == file_reg
                            && mem_rdata.page == page_reg) begin
                            found_reg     <= 1'b1;
                            found_idx_reg <= rd_idx;
                        end
                        if (!pin_reg[rd_idx] && (!best_ok_reg[cls]
                            || mem_rdata.stamp < best_st_reg[cls])) begin
                            best_ok_reg[cls]  <= 1'b1;
                            best_idx_reg[cls] <= rd_idx;
                            best_st_reg[cls]  <= mem_rdata.stamp;
                        end
                    end
                end
                S_DECIDE: begin
                    out_reg <= '0;
                    scan_reg <= '0;
                    if (cmd_reg > CMD_SPILL) begin
                        out_reg[1:0] <= ST_NOT_RES;
                    end else if (found_reg) begin
                        out_reg[5:2] <= found_idx_reg;
                        out_reg[6]   <= 1'b1;
                        case (cmd_reg)
                            CMD_ACCESS: opc_reg <= opc_reg + 32'd1;
                            CMD_DIRTY: begin
                                dirty_reg[found_idx_reg] <= 1'b1;
                                opc_reg <= opc_reg + 32'd1;
                            end
                            CMD_FLUSH: begin
                                out_reg[8] <= 1'b1;
                                out_reg[16:9]  <= file_reg;
                                out_reg[32:17] <= page_reg;
                                dirty_reg[found_idx_reg] <= 1'b0;
                            end
                            CMD_PIN:   pin_reg[found_idx_reg] <= 1'b1;
                            CMD_UNPIN: pin_reg[found_idx_reg] <= 1'b0;
                            default:   spill_reg[found_idx_reg] <= 1'b1;
                        endcase
                        // Hit stamp: rewrite the entry with the current counter.
                        if (cmd_reg == CMD_ACCESS || cmd_reg == CMD_DIRTY) begin
                            tgt_reg <= found_idx_reg;
                        end
                    end else if (!place_cmd) begin
                        out_reg[1:0] <= ST_NOT_RES;
                    end else if (use_empty) begin
                        tgt_reg <= SLOT_W'(occ_reg);
                        occ_reg <= occ_reg + CNT_W'(1);
                    end else if (vic_ok) begin
                        tgt_reg <= vic_idx;
                    end else begin
                        out_reg[1:0] <= ST_NO_VICTIM;
                    end
                end
                S_RDVIC: begin
                    if (dirty_reg[tgt_reg]) begin
                        out_reg[8] <= 1'b1;
                        out_reg[16:9]  <= mem_rdata.file;
                        out_reg[32:17] <= mem_rdata.page;
                    end
                end
                S_WRITE: begin
                    valid_reg[tgt_reg] <= 1'b1;
                    pin_reg[tgt_reg]   <= 1'b0;
                    dirty_reg[tgt_reg] <= 1'b0;
                    spill_reg[tgt_reg] <= (cmd_reg == CMD_SPILL);
                    opc_reg            <= opc_reg + 32'd1;
                    out_reg[5:2]       <= tgt_reg;
                    out_reg[7]         <= (cmd_reg == CMD_ACCESS);
                end
                S_OUT: out_valid_reg <= 1'b1;
                default: ;
            endcase
        end
    end

    // Hit stamping writes the memory in S_OUT using the counter value before
    // the increment made in S_DECIDE.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_stamp_reg <= 1'b0;
        end else begin
            hit_stamp_reg <= (state_reg == S_DECIDE) && found_reg
                             && (cmd_reg == CMD_ACCESS || cmd_reg == CMD_DIRTY);
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WRITE) |-> !(valid_reg[tgt_reg] && pin_reg[tgt_reg]))
        else $error("pinned slot overwritten");
    assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= CNT_W'(SLOTS)) else $error("occupancy overflow");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WRITE) |=> valid_reg[$past(tgt_reg)])
        else $error("placed slot not valid");
endmodule
`default_nettype wire

// ----- src/pbplru_mem.sv -----
`default_nettype none
module pbplru_mem
    import pbplru_pkg::*;
(
    input  wire  logic              aclk,
    input  wire  logic              we,
    input  wire  logic [SLOT_W-1:0] waddr,
    input  wire  entry_t            wdata,
    input  wire  logic [SLOT_W-1:0] raddr,
    output entry_t                  rdata
);
    entry_t mem [SLOTS];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire
